// ===== sv/rsc_pkg.sv =====
// Shared types and constants of the reachability and strong component block.
// No dependencies; imported by the controller, the datapath and the top level.
package rsc_pkg;

    // Field widths fixed by the request and result formats.
    localparam int VW    = 5;
    localparam int MASKW = 32;
    localparam int CNTW  = 6;
    localparam int LABW  = 5;
    localparam int ROWS  = 32;

    // Request function codes.
    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_RUN   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_DIRECTED     = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic          load_edge;
        logic          clear_adj;
        logic          start_run;
        logic          copy_row;
        logic          close_step;
        logic          emit;
        logic          last;
        logic [VW-1:0] idx;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CNTW-1:0] count;
        logic            slot_free;
    } t_status;

endpackage

// ===== sv/reachability_and_strong_components.sv =====
// Top level of the reachability and strong component block.
// Instantiates rsc_ctrl and rsc_datapath; uses rsc_pkg.
//
// Usage:
// Requests enter on i_valid/o_stall with i_func, i_src_vertex and i_dst_vertex.
// Add edge and clear requests never raise o_stall, so edges load back to back.
// A run request with vertices in use holds o_stall high through its sweeps:
// the copy sweep copies the adjacency rows, the closure sweep applies one
// closure pivot per vertex, and the emit sweep emits one result per vertex,
// lowest vertex first, o_last on the final one.
// The closure pivot reads one reach row per cycle and the emit sweep reads
// one row and one column per cycle while the output slot is free.
// Results leave on o_valid/i_stall through an output register; while i_stall
// holds a result, the emit sweep pauses and nothing is lost.
// A run with a vertex count of zero emits nothing and never raises o_stall.
// Configuration writes (vertex count, directed mode) use i_cfg_valid and
// o_cfg_ready, always high; the user must make them while the block is idle,
// as the block does not enforce it. Synchronous reset empties the graph, sets
// 32 vertices in directed mode and drops any pending result.
module reachability_and_strong_components
    import rsc_pkg::*;
#(
    parameter int MAX_VERTICES = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [CNTW-1:0]  i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_func,
    input  logic [VW-1:0]    i_src_vertex,
    input  logic [VW-1:0]    i_dst_vertex,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [VW-1:0]    o_vertex,
    output logic [MASKW-1:0] o_reach_mask,
    output logic [LABW-1:0]  o_component,
    output logic             o_last
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    rsc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    rsc_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_src_vertex (i_src_vertex),
        .i_dst_vertex (i_dst_vertex),
        .i_cmd        (cmd),
        .i_stall      (i_stall),
        .o_status     (status),
        .o_valid      (o_valid),
        .o_vertex     (o_vertex),
        .o_reach_mask (o_reach_mask),
        .o_component  (o_component),
        .o_last       (o_last)
    );

    // A result is loaded only into a free output slot.
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> status.slot_free)
        else $error("result loaded into an occupied output slot");

    // At most one datapath operation per cycle.
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load_edge, cmd.clear_adj, cmd.copy_row, cmd.close_step, cmd.emit}))
        else $error("conflicting datapath commands");

    // A run with vertices in use stalls the request channel in the next cycle.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_func == FUNC_RUN && status.count != '0) |=> o_stall)
        else $error("run request did not start the sweep");

    // The final result of a run describes the last vertex in use.
    a_last_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (({1'b0, o_vertex} + CNTW'(1)) == status.count))
        else $error("last flag on the wrong vertex");

endmodule

// ===== sv/rsc_ctrl.sv =====
// Sequencer of the reachability block: request decode and the copy, closure
// and emit sweeps. Depends on rsc_pkg for the command and status structs.
module rsc_ctrl
    import rsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_func,
    input  t_status    i_status,
    output logic       o_stall,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_COPY  = 4'b0010,
        S_CLOSE = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            cnt_last;

    // The sweep counter ends on the last vertex in use.
    assign cnt_last = (r_cnt == CNTW'(i_status.count - CNTW'(1)));
    assign o_stall  = (r_state != S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state          = r_state;
        n_cnt            = r_cnt;
        o_cmd            = '0;
        o_cmd.idx        = r_cnt[VW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_func)
                        FUNC_ADD:   o_cmd.load_edge = 1'b1;
                        FUNC_CLEAR: o_cmd.clear_adj = 1'b1;
                        FUNC_RUN: begin
                            if (i_status.count != '0) begin
                                o_cmd.start_run = 1'b1;
                                n_cnt           = '0;
                                n_state         = S_COPY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_COPY: begin
                o_cmd.copy_row = 1'b1;
                n_cnt          = cnt_last ? '0 : r_cnt + CNTW'(1);
                if (cnt_last) n_state = S_CLOSE;
            end
            S_CLOSE: begin
                o_cmd.close_step = 1'b1;
                n_cnt            = cnt_last ? '0 : r_cnt + CNTW'(1);
                if (cnt_last) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = cnt_last;
                    n_cnt      = r_cnt + CNTW'(1);
                    if (cnt_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== sv/rsc_datapath.sv =====
// Datapath of the reachability block: configuration, adjacency matrix, reach
// rows with the closure update, component labels and output register. Uses rsc_pkg.
module rsc_datapath
    import rsc_pkg::*;
#(
    parameter int MAX_VERTICES = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CNTW-1:0]  i_cfg_data,
    input  logic [VW-1:0]    i_src_vertex,
    input  logic [VW-1:0]    i_dst_vertex,
    input  t_cmd             i_cmd,
    input  logic             i_stall,
    output t_status          o_status,
    output logic             o_valid,
    output logic [VW-1:0]    o_vertex,
    output logic [MASKW-1:0] o_reach_mask,
    output logic [LABW-1:0]  o_component,
    output logic             o_last
);

    localparam int VLIMIT = (MAX_VERTICES < ROWS) ? MAX_VERTICES : ROWS;
    localparam int IW     = $clog2(VLIMIT);

    logic [CNTW-1:0]  r_vertex_count;
    logic             r_directed;
    logic [CNTW-1:0]  n_eff;
    logic [MASKW-1:0] live;
    logic             edge_ok;

    logic [MASKW-1:0] r_adj   [VLIMIT];
    logic [MASKW-1:0] set_row [VLIMIT];
    logic [MASKW-1:0] r_reach [VLIMIT];
    logic [LABW-1:0]  r_label [VLIMIT];
    logic [VLIMIT-1:0] r_labeled;
    logic [LABW-1:0]  r_next;

    logic [IW-1:0]    ridx;
    logic [MASKW-1:0] adj_rd;
    logic [MASKW-1:0] pivot;
    logic [MASKW-1:0] col;
    logic [MASKW-1:0] above;
    logic [MASKW-1:0] mutual;
    logic             fresh;
    logic [LABW-1:0]  label_out;

    logic             r_out_valid;
    logic [VW-1:0]    r_vertex;
    logic [MASKW-1:0] r_reach_mask;
    logic [LABW-1:0]  r_component;
    logic             r_last;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= CNTW'(32);
            r_directed     <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data;
                CFG_DIRECTED:     r_directed     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective vertex count and the mask of vertices in use.
    assign n_eff = (r_vertex_count > CNTW'(VLIMIT)) ? CNTW'(VLIMIT) : r_vertex_count;
    always_comb begin
        for (int j = 0; j < MASKW; j++) begin
            live[j] = (CNTW'(j) < n_eff);
        end
    end

    assign edge_ok = ({1'b0, i_src_vertex} < n_eff) && ({1'b0, i_dst_vertex} < n_eff);

    // Bits that an added edge sets in each adjacency row.
    always_comb begin
        for (int i = 0; i < VLIMIT; i++) begin
            set_row[i] = '0;
            if (i_src_vertex == VW'(i)) begin
                set_row[i] = set_row[i] | (MASKW'(1) << i_dst_vertex);
            end
            if (!r_directed && i_dst_vertex == VW'(i)) begin
                set_row[i] = set_row[i] | (MASKW'(1) << i_src_vertex);
            end
        end
    end

    // Adjacency matrix, cleared at reset and by the clear request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_adj) begin
            for (int i = 0; i < VLIMIT; i++) r_adj[i] <= '0;
        end else if (i_cmd.load_edge && edge_ok) begin
            for (int i = 0; i < VLIMIT; i++) r_adj[i] <= r_adj[i] | set_row[i];
        end
    end

    // Row selected by the sweep index.
    assign ridx   = i_cmd.idx[IW-1:0];
    assign adj_rd = r_adj[ridx];
    assign pivot  = r_reach[ridx];

    // Reach rows: the copy sweep loads the live adjacency, then each closure
    // step adds the pivot row to every row that already reaches the pivot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.copy_row) begin
            r_reach[ridx] <= adj_rd & live;
        end else if (i_cmd.close_step) begin
            for (int i = 0; i < VLIMIT; i++) begin
                if (r_reach[i][i_cmd.idx]) r_reach[i] <= r_reach[i] | pivot;
            end
        end
    end

    // Later vertices mutually reachable with the current one.
    always_comb begin
        col = '0;
        for (int y = 0; y < VLIMIT; y++) col[y] = r_reach[y][i_cmd.idx];
        for (int j = 0; j < MASKW; j++) above[j] = (VW'(j) > i_cmd.idx) && (j < ROWS);
    end
    assign mutual    = pivot & col & above & live;
    assign fresh     = !r_labeled[ridx];
    assign label_out = fresh ? r_next : r_label[ridx];

    // Component labels: an unlabeled vertex opens a new label for its component.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.start_run) begin
            r_labeled <= '0;
            r_next    <= '0;
        end else if (i_cmd.emit && fresh) begin
            for (int y = 0; y < VLIMIT; y++) begin
                if (mutual[y]) r_labeled[y] <= 1'b1;
            end
            r_next <= r_next + LABW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && fresh) begin
            for (int y = 0; y < VLIMIT; y++) begin
                if (mutual[y]) r_label[y] <= r_next;
            end
        end
    end

    // Output register; a new result loads when the slot is empty or being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_vertex     <= i_cmd.idx;
            r_reach_mask <= pivot & ~(MASKW'(1) << i_cmd.idx);
            r_component  <= label_out;
            r_last       <= i_cmd.last;
        end
    end

    assign o_status.count     = n_eff;
    assign o_status.slot_free = !r_out_valid || !i_stall;
    assign o_valid            = r_out_valid;
    assign o_vertex           = r_vertex;
    assign o_reach_mask       = r_reach_mask;
    assign o_component        = r_component;
    assign o_last             = r_last;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the reachability and strong component block.
// Needs rsc_pkg and reachability_and_strong_components; holds its own graph model.

// One expected or observed per-vertex result of a run.
typedef struct packed {
    logic [rsc_pkg::VW-1:0]    vertex;
    logic [rsc_pkg::MASKW-1:0] reach_mask;
    logic [rsc_pkg::LABW-1:0]  component;
    logic                      last;
} t_vertex_result;

// Graph model plus the queue of results still owed by the block.
class closure_scoreboard;
    logic [rsc_pkg::MASKW-1:0] adjacency [rsc_pkg::ROWS];
    logic [rsc_pkg::CNTW-1:0]  vertex_count;
    logic                      directed_mode;
    int                        max_vertices;
    t_vertex_result            owed_results [$];
    int                        errors;

    function new(int max_v);
        max_vertices = max_v;
        foreach (adjacency[i]) adjacency[i] = '0;
        vertex_count  = 6'd32;
        directed_mode = 1'b1;
        errors        = 0;
    endfunction

    function int effective_count();
        int n;
        n = int'(vertex_count);
        if (n > max_vertices) n = max_vertices;
        if (n > rsc_pkg::ROWS) n = rsc_pkg::ROWS;
        return n;
    endfunction

    function void write_register(logic index, logic [rsc_pkg::CNTW-1:0] data);
        if (index == rsc_pkg::CFG_VERTEX_COUNT) begin
            vertex_count = data;
        end else begin
            directed_mode = data[0];
        end
    endfunction

    // Update the graph for an accepted request; a run queues one result per vertex.
    function void note_request(logic [1:0] func, logic [rsc_pkg::VW-1:0] src,
                               logic [rsc_pkg::VW-1:0] dst);
        int n;
        logic [rsc_pkg::MASKW-1:0] live, seen, prev;
        logic [rsc_pkg::MASKW-1:0] reach [rsc_pkg::ROWS];
        logic [rsc_pkg::LABW-1:0]  label [rsc_pkg::ROWS];
        bit                        labeled [rsc_pkg::ROWS];
        logic [rsc_pkg::LABW-1:0]  next_label;
        t_vertex_result            res;
        n = effective_count();
        case (func)
            rsc_pkg::FUNC_ADD: begin
                if (src < n && dst < n) begin
                    adjacency[src][dst] = 1'b1;
                    if (!directed_mode) adjacency[dst][src] = 1'b1;
                end
            end
            rsc_pkg::FUNC_CLEAR: begin
                foreach (adjacency[i]) adjacency[i] = '0;
            end
            rsc_pkg::FUNC_RUN: begin
                live = (n >= 32) ? '1 : ((32'd1 << n) - 32'd1);
                // Grow each source's frontier until it stops changing.
                for (int x = 0; x < n; x++) begin
                    seen = adjacency[x] & live;
                    do begin
                        prev = seen;
                        for (int v = 0; v < n; v++)
                            if (seen[v]) seen |= adjacency[v] & live;
                    end while (seen != prev);
                    reach[x] = seen & ~(32'd1 << x);
                end
                // Components take labels in order of their lowest vertex.
                foreach (labeled[i]) labeled[i] = 1'b0;
                next_label = '0;
                for (int x = 0; x < n; x++) begin
                    if (!labeled[x]) begin
                        label[x]   = next_label;
                        labeled[x] = 1'b1;
                        for (int y = x + 1; y < n; y++) begin
                            if (reach[x][y] && reach[y][x]) begin
                                label[y]   = next_label;
                                labeled[y] = 1'b1;
                            end
                        end
                        next_label = next_label + 1'b1;
                    end
                end
                for (int x = 0; x < n; x++) begin
                    res.vertex     = x[rsc_pkg::VW-1:0];
                    res.reach_mask = reach[x];
                    res.component  = label[x];
                    res.last       = (x + 1 == n);
                    owed_results   = {owed_results, res};
                end
            end
            default: ;
        endcase
    endfunction

    // Compare an accepted result with the oldest one owed.
    function void check_result(t_vertex_result got);
        t_vertex_result want;
        if (owed_results.size() == 0) begin
            $error("result for vertex %0d arrived with none expected", got.vertex);
            errors++;
            return;
        end
        want = owed_results.pop_front();
        if (got.vertex !== want.vertex) begin
            $error("vertex: expected %0d, got %0d", want.vertex, got.vertex);
            errors++;
        end
        if (got.reach_mask !== want.reach_mask) begin
            $error("reach_mask: expected %h, got %h", want.reach_mask, got.reach_mask);
            errors++;
        end
        if (got.component !== want.component) begin
            $error("component: expected %0d, got %0d", want.component, got.component);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb;
    import rsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         MAX_VERTS    = 32;
    localparam int         DRAIN_CYCLES = 3 * MAX_VERTS + 16;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic             i_cfg_index;
    logic [CNTW-1:0]  i_cfg_data;
    logic             i_valid;
    logic             o_stall;
    logic [1:0]       i_func;
    logic [VW-1:0]    i_src_vertex;
    logic [VW-1:0]    i_dst_vertex;
    logic             o_valid;
    logic             i_stall;
    logic [VW-1:0]    o_vertex;
    logic [MASKW-1:0] o_reach_mask;
    logic [LABW-1:0]  o_component;
    logic             o_last;

    closure_scoreboard sb;
    int burst_left;
    int sender_gap_max;
    int stall_mode;
    int stall_mode_cycles;

    int phase_counts [8] = '{5, 1, 32, 63, 8, 0, 33, 17};
    int phase_modes  [8] = '{0, 1, 1, 0, 1, 0, 1, 0};

    reachability_and_strong_components #(
        .MAX_VERTICES(MAX_VERTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_src_vertex (i_src_vertex),
        .i_dst_vertex (i_dst_vertex),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_vertex     (o_vertex),
        .o_reach_mask (o_reach_mask),
        .o_component  (o_component),
        .o_last       (o_last)
    );

    // 12 ns clock.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Receiver back-pressure: switches between free-running, light, even and heavy stalls.
    always @(negedge i_clk) begin
        if (stall_mode_cycles == 0) begin
            stall_mode        = $urandom_range(0, 3);
            stall_mode_cycles = $urandom_range(20, 120);
        end else begin
            stall_mode_cycles--;
        end
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            2:       i_stall <= 1'($urandom_range(0, 1));
            default: i_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // Observe every handshake at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_register(i_cfg_index, i_cfg_data);
            if (i_valid && !o_stall) sb.note_request(i_func, i_src_vertex, i_dst_vertex);
            if (o_valid && !i_stall)
                sb.check_result('{o_vertex, o_reach_mask, o_component, o_last});
        end
    end

    // Present one request, with a random gap at the end of each burst.
    task automatic send_request(input logic [1:0] func, input logic [VW-1:0] src,
                                input logic [VW-1:0] dst);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, sender_gap_max);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_func       <= func;
        i_src_vertex <= src;
        i_dst_vertex <= dst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic write_register(input logic index, input logic [CNTW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop sending, collect every owed result, then let any silent work finish.
    task automatic wait_quiet();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Short hand-picked sequence: extremes, cycles, self loop, stale and ignored edges.
    task automatic directed_requests();
        send_request(FUNC_RUN, 5'd0, 5'd0);
        send_request(FUNC_ADD, 5'd0, 5'd31);
        send_request(FUNC_ADD, 5'd31, 5'd0);
        send_request(FUNC_ADD, 5'd5, 5'd5);
        send_request(FUNC_ADD, 5'd1, 5'd2);
        send_request(FUNC_ADD, 5'd2, 5'd3);
        send_request(FUNC_ADD, 5'd3, 5'd1);
        send_request(FUNC_ADD, 5'd3, 5'd4);
        send_request(FUNC_UNUSED, 5'd31, 5'd31);
        send_request(FUNC_RUN, 5'd31, 5'd0);
        send_request(FUNC_CLEAR, 5'd31, 5'd31);
        send_request(FUNC_RUN, 5'd0, 5'd31);
        send_request(FUNC_ADD, 5'd20, 5'd2);
        send_request(FUNC_ADD, 5'd2, 5'd20);
        send_request(FUNC_ADD, 5'd0, 5'd1);
        wait_quiet();
        // Shrinking the count leaves edges to vertex 20 stored but unused.
        write_register(CFG_VERTEX_COUNT, 6'd4);
        send_request(FUNC_ADD, 5'd2, 5'd10);
        send_request(FUNC_ADD, 5'd3, 5'd0);
        send_request(FUNC_RUN, 5'd0, 5'd0);
        wait_quiet();
        write_register(CFG_VERTEX_COUNT, 6'd0);
        send_request(FUNC_RUN, 5'd0, 5'd0);
        send_request(FUNC_ADD, 5'd0, 5'd0);
        wait_quiet();
        write_register(CFG_VERTEX_COUNT, 6'd32);
        write_register(CFG_DIRECTED, 6'd0);
        send_request(FUNC_ADD, 5'd6, 5'd7);
        send_request(FUNC_RUN, 5'd0, 5'd0);
        send_request(FUNC_CLEAR, 5'd0, 5'd0);
        send_request(FUNC_ADD, 5'd31, 5'd30);
        send_request(FUNC_RUN, 5'd31, 5'd31);
        wait_quiet();
    endtask

    // Mostly clear, a cluster of edges, run; the rest are stray requests.
    task automatic random_requests(input int quota);
        int sent, n, edges, width, base;
        logic [1:0]    f;
        logic [VW-1:0] src, dst;
        sent = 0;
        while (sent < quota) begin
            n = sb.effective_count();
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 9) < 7) begin
                    send_request(FUNC_CLEAR, VW'($urandom_range(0, 31)),
                                 VW'($urandom_range(0, 31)));
                    sent++;
                end
                edges = $urandom_range(0, 10);
                width = (n == 0) ? 1 : $urandom_range(1, n);
                base  = (n == 0) ? 0 : $urandom_range(0, n - width);
                for (int k = 0; k < edges; k++) begin
                    // A few edges land anywhere, some beyond the count.
                    src = VW'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                          : base + $urandom_range(0, width - 1));
                    dst = VW'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                          : base + $urandom_range(0, width - 1));
                    send_request(FUNC_ADD, src, dst);
                    sent++;
                end
                send_request(FUNC_RUN, VW'($urandom_range(0, 31)), VW'($urandom_range(0, 31)));
                sent++;
            end else begin
                f = 2'($urandom_range(0, 3));
                send_request(f, VW'($urandom_range(0, 31)), VW'($urandom_range(0, 31)));
                if (f != FUNC_UNUSED) sent++;
            end
        end
    endtask

    initial begin
        sb                = new(MAX_VERTS);
        burst_left        = 0;
        sender_gap_max    = 4;
        stall_mode        = 0;
        stall_mode_cycles = 0;
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = CFG_VERTEX_COUNT;
        i_cfg_data        = '0;
        i_valid           = 1'b0;
        i_func            = FUNC_ADD;
        i_src_vertex      = '0;
        i_dst_vertex      = '0;
        i_stall           = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_requests();

        // Random phases over a spread of counts, both modes and sender rates.
        for (int p = 0; p < 8; p++) begin
            sender_gap_max = (p % 3 == 0) ? 0 : $urandom_range(2, 6);
            write_register(CFG_VERTEX_COUNT, CNTW'(phase_counts[p]));
            write_register(CFG_DIRECTED, CNTW'(phase_modes[p]));
            random_requests(13);
            wait_quiet();
        end

        if (sb.errors == 0 && sb.owed_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #10ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
